[hw/rtl/fpc_pkg.sv]
`default_nettype none

package fpc_pkg;

    // Flash geometry. Both sizes are powers of two, so the wrap of an address
    // is a truncation to the address width.
    localparam int FLASH_BYTES = 131072;
    localparam int PAGE_BYTES  = 128;
    localparam int ADDR_W      = $clog2(FLASH_BYTES);
    localparam int PAGE_W      = $clog2(PAGE_BYTES);

    localparam logic [7:0] BYTE_ERASED = 8'hFF;

    localparam logic [63:0] STATUS_ERASE  = 64'h1111800800C20000;
    localparam logic [63:0] STATUS_OFFSET = 64'h1111800400C20000;
    localparam logic [63:0] STATUS_STATUS = 64'h1111800100C20000;
    localparam logic [63:0] STATUS_READ   = 64'h11118004F0000000;

    typedef enum logic [1:0] {
        CMD_WORD   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    // Opcodes live in the top byte of a command word.
    typedef enum logic [7:0] {
        OP_OFFSET        = 8'h4B,
        OP_ERASE         = 8'h78,
        OP_OFFSET_STATUS = 8'hA5,
        OP_WRITE         = 8'hB4,
        OP_EXECUTE       = 8'hD2,
        OP_STATUS        = 8'hE1,
        OP_READ          = 8'hF0
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ERASE  = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_STATUS = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_RESULT
    } fsm_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] cmd_word;
        logic [6:0]  buffer_index;
        logic [7:0]  buffer_byte;
        logic [16:0] read_offset;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [63:0] status_value;
        logic        fault;
        logic        dirty;
    } rsp_t;

    // What one request does to the controller state.
    typedef struct packed {
        logic              fault;
        logic              mode_load;
        mode_t             mode_val;
        logic              status_load;
        logic [63:0]       status_val;
        logic              offset_load;
        logic [ADDR_W-1:0] offset_val;
        logic              buf_write;
        logic              flash_read;
        logic              exec_start;
        logic              exec_erase;
    } dec_t;

endpackage

`default_nettype wire

[hw/rtl/fpc_ram.sv]
`default_nettype none

module fpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data is registered and holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/fpc_decode.sv]
`default_nettype none

module fpc_decode
    import fpc_pkg::*;
(
    input  wire req_t  req,
    input  wire mode_t mode,
    output dec_t       dec
);

    // The page number scaled to bytes, wrapped to the flash size.
    function automatic logic [ADDR_W-1:0] page_address(input logic [15:0] page);
        logic [31:0] wide;
        wide = 32'(page) << PAGE_W;
        return wide[ADDR_W-1:0];
    endfunction

    always_comb
    begin
        dec = '0;
        dec.mode_val = MODE_IDLE;
        unique case (req.command)
            CMD_WORD:
            begin
                unique case (req.cmd_word[31:24])
                    OP_OFFSET:
                    begin
                        dec.offset_load = 1'b1;
                        dec.offset_val  = page_address(req.cmd_word[15:0]);
                    end
                    OP_ERASE:
                    begin
                        dec.mode_load   = 1'b1;
                        dec.mode_val    = MODE_ERASE;
                        dec.status_load = 1'b1;
                        dec.status_val  = STATUS_ERASE;
                    end
                    OP_OFFSET_STATUS:
                    begin
                        dec.offset_load = 1'b1;
                        dec.offset_val  = page_address(req.cmd_word[15:0]);
                        dec.status_load = 1'b1;
                        dec.status_val  = STATUS_OFFSET;
                    end
                    OP_WRITE:
                    begin
                        dec.mode_load = 1'b1;
                        dec.mode_val  = MODE_WRITE;
                    end
                    OP_EXECUTE:
                    begin
                        // Execute always drops back to idle; only erase and
                        // write modes touch the flash.
                        dec.mode_load = 1'b1;
                        dec.mode_val  = MODE_IDLE;
                        if (mode == MODE_ERASE)
                        begin
                            dec.exec_start = 1'b1;
                            dec.exec_erase = 1'b1;
                        end
                        else if (mode == MODE_WRITE)
                        begin
                            dec.exec_start = 1'b1;
                        end
                        else if (mode == MODE_READ)
                        begin
                            dec.fault = 1'b1;
                        end
                    end
                    OP_STATUS:
                    begin
                        dec.mode_load   = 1'b1;
                        dec.mode_val    = MODE_STATUS;
                        dec.status_load = 1'b1;
                        dec.status_val  = STATUS_STATUS;
                    end
                    OP_READ:
                    begin
                        dec.mode_load   = 1'b1;
                        dec.mode_val    = MODE_READ;
                        dec.status_load = 1'b1;
                        dec.status_val  = STATUS_READ;
                    end
                    default:
                    begin
                        dec.fault = 1'b1;
                    end
                endcase
            end
            CMD_LOAD:
            begin
                if (mode == MODE_WRITE)
                begin
                    dec.buf_write = 1'b1;
                end
                else
                begin
                    dec.fault = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (mode == MODE_READ)
                begin
                    dec.flash_read = 1'b1;
                end
                else
                begin
                    dec.fault = 1'b1;
                end
            end
            CMD_STATUS:
            begin
                dec.fault = 1'b0;
            end
            default:
            begin
                dec.fault = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/flash_page_command_controller_unit.sv]
// Each request passes through the states in order: a command word, buffer
// load or status read goes from idle to the result state; a data read passes
// the read state first; an execute that erases or programs a page walks it
// in the exec state, one byte at a time through the single write port.
// One request at a time: req_stall stays high until the result moves from
// res_reg to the output register, which can be held back by rsp_stall.
// Reset: asynchronous, active low; afterwards the flash is swept to 0xFF one
// byte a cycle, with req_stall held high.
`default_nettype none

module flash_page_command_controller_unit
    import fpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    // Controller state. The flash contents and the page buffer live in the
    // two RAMs; everything else is a handful of registers.
    fsm_t              state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [63:0]       status_reg, status_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic              written_reg, written_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PAGE_W:0]   walk_cnt_reg, walk_cnt_next;
    logic              erase_reg, erase_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    dec_t              dec;
    logic [PAGE_W:0]   walk_prev;

    // Memory ports.
    logic              flash_we;
    logic [ADDR_W-1:0] flash_waddr;
    logic [7:0]        flash_wdata;
    logic              flash_re;
    logic [7:0]        flash_rdata;
    logic              buf_we;
    logic              buf_re;
    logic [7:0]        buf_rdata;

    fpc_decode u_decode (
        .req  (req),
        .mode (mode_reg),
        .dec  (dec)
    );

    fpc_ram #(
        .WIDTH (8),
        .DEPTH (FLASH_BYTES)
    ) u_flash (
        .clk   (clk),
        .we    (flash_we),
        .waddr (flash_waddr),
        .wdata (flash_wdata),
        .re    (flash_re),
        .raddr (ADDR_W'(req.read_offset)),
        .rdata (flash_rdata)
    );

    // The page buffer is written by buffer loads and read back in order
    // during a program walk.
    assign buf_we = req_valid && (state_reg == ST_IDLE) && dec.buf_write;

    fpc_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (PAGE_W'(req.buffer_index)),
        .wdata (req.buffer_byte),
        .re    (buf_re),
        .raddr (walk_cnt_reg[PAGE_W-1:0]),
        .rdata (buf_rdata)
    );

    // Requests are taken only in idle; the response register lets a new
    // request come in while the previous result still waits downstream.
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // The walk writes byte i in the cycle after the buffer read of byte i.
    assign walk_prev = walk_cnt_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        written_next   = written_reg;
        clr_cnt_next   = clr_cnt_reg;
        walk_cnt_next  = walk_cnt_reg;
        erase_next     = erase_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        flash_we       = 1'b0;
        flash_waddr    = clr_cnt_reg;
        flash_wdata    = BYTE_ERASED;
        flash_re       = 1'b0;
        buf_re         = 1'b0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Post-reset sweep: every flash byte gets the erased value.
                flash_we     = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    // All register updates land at the transfer; the
                    // response is assembled from the post-request state.
                    if (dec.mode_load)
                    begin
                        mode_next = dec.mode_val;
                    end
                    if (dec.status_load)
                    begin
                        status_next = dec.status_val;
                    end
                    if (dec.offset_load)
                    begin
                        offset_next = dec.offset_val;
                    end
                    if (dec.exec_start)
                    begin
                        written_next = 1'b1;
                    end
                    res_next.read_byte    = 8'h00;
                    res_next.status_value = dec.status_load ? dec.status_val : status_reg;
                    res_next.fault        = dec.fault;
                    res_next.dirty        = dec.exec_start | written_reg;
                    if (dec.flash_read)
                    begin
                        flash_re   = 1'b1;
                        state_next = ST_READ;
                    end
                    else if (dec.exec_start)
                    begin
                        walk_cnt_next = '0;
                        erase_next    = dec.exec_erase;
                        state_next    = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_READ:
            begin
                res_next.read_byte = flash_rdata;
                state_next         = ST_RESULT;
            end
            ST_EXEC:
            begin
                // Buffer reads run one step ahead of the flash writes.
                buf_re = !walk_cnt_reg[PAGE_W];
                if (walk_cnt_reg != '0)
                begin
                    flash_we    = 1'b1;
                    flash_waddr = offset_reg + ADDR_W'(walk_prev[PAGE_W-1:0]);
                    flash_wdata = erase_reg ? BYTE_ERASED : buf_rdata;
                end
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg[PAGE_W])
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            status_reg    <= '0;
            offset_reg    <= '0;
            written_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
            walk_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            status_reg    <= status_next;
            offset_reg    <= offset_next;
            written_reg   <= written_next;
            clr_cnt_reg   <= clr_cnt_next;
            walk_cnt_reg  <= walk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        erase_reg <= erase_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

[hw/rtl/fpc_checker.sv]
`default_nettype none

module fpc_checker
    import fpc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    logic       req_xfer;
    logic       rsp_xfer;
    logic [1:0] pend_reg;
    logic       seen_dirty_reg;

    assign req_xfer = req_valid && !req_stall;
    assign rsp_xfer = rsp_valid && !rsp_stall;

    // Requests taken whose response has not yet been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 2'd0;
            seen_dirty_reg <= 1'b0;
        end
        else
        begin
            if (req_xfer && !rsp_xfer)
            begin
                pend_reg <= pend_reg + 2'd1;
            end
            else if (!req_xfer && rsp_xfer)
            begin
                pend_reg <= pend_reg - 2'd1;
            end
            if (rsp_xfer && rsp.dirty)
            begin
                seen_dirty_reg <= 1'b1;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("more than two requests outstanding");

    a_rsp_owed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without a matching request");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_xfer && seen_dirty_reg |-> rsp.dirty)
        else $error("dirty flag cleared after a flash change");

    a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status_value == 64'd0 || rsp.status_value == STATUS_ERASE
            || rsp.status_value == STATUS_OFFSET || rsp.status_value == STATUS_STATUS
            || rsp.status_value == STATUS_READ)
        else $error("status value is not a known pattern");

endmodule

bind flash_page_command_controller_unit fpc_checker u_fpc_checker (.*);

`default_nettype wire
